>>> rtl/core/sdsr_pkg.sv
// Shared types, constants and the CRC-16 step for the SD SPI card responder.
// Used by every module of the responder core but sdsr_ram; depends on nothing else.
package sdsr_pkg;

    // Card image store.
    localparam int ADDR_W       = 15;
    localparam int STORE_BYTES  = 1 << ADDR_W;
    localparam int BLOCK_BYTES  = 512;
    localparam int STORE_BLOCKS = STORE_BYTES / BLOCK_BYTES;
    localparam int IMAGE_BLOCKS = 64;
    localparam int BLOCK_LIMIT  = (IMAGE_BLOCKS < STORE_BLOCKS) ? IMAGE_BLOCKS : STORE_BLOCKS;
    localparam int BLOCK_W      = 23;

    // Read transfer: start token, one block of data, two CRC bytes.
    localparam int POS_W       = 10;
    localparam int READ_LENGTH = BLOCK_BYTES + 1 + 2;

    // Fixed bytes on the line.
    localparam logic [7:0] START_TOKEN = 8'hFE;
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] R1_ILLEGAL  = 8'h04;
    localparam logic [7:0] R1_READY    = 8'h00;
    localparam logic [7:0] FRAME_MASK  = 8'hC0;
    localparam logic [7:0] FRAME_START = 8'h40;

    // Command indexes (low six bits of the first command byte).
    localparam logic [5:0] CMD_GO_IDLE       = 6'h00;
    localparam logic [5:0] CMD_SEND_IF_COND  = 6'h08;
    localparam logic [5:0] CMD_STOP_TRANS    = 6'h0C;
    localparam logic [5:0] CMD_READ_SINGLE   = 6'h11;
    localparam logic [5:0] CMD_APP_CMD       = 6'h37;
    localparam logic [5:0] ACMD_SEND_OP_COND = 6'h29;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Source of the returned byte.
    typedef enum logic [1:0] {
        SEL_LIT,
        SEL_MEM,
        SEL_CRC_HI,
        SEL_CRC_LO
    } miso_sel_t;

    // Instruction for the output stage, one per exchanged word.
    typedef struct packed {
        miso_sel_t  sel;
        logic [7:0] lit;
        logic       data_phase;
        logic       crc_upd;
        logic       crc_clr;
    } byte_op_t;

    // One byte into a CRC-16 (MSB first).
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/sd_card_spi_responder_core.sv
// Top level of the SD card SPI-mode responder: sequencer, card image RAM and output stage.
// Depends on sdsr_pkg, sdsr_ram, sdsr_cmd and sdsr_out.
//
//  channel | ports                                                  | direction
//  s_      | s_valid s_ready s_mode s_mosi_byte s_load_address      | in
//          | s_card_detect_open                                     |
//  m_      | m_valid m_ready m_miso_byte m_data_phase               | out
//
// One word is taken every cycle while s_ready is high; a result passes from its exchange
// word through the middle stage (with the image RAM read) to the output register. Load words write
// the image RAM and give no result. Reset clears the sequencer, CRC and pipeline; the
// card image is kept. When the result is not taken, the middle stage fills and s_ready
// drops until the output register drains.
module sd_card_spi_responder_core #(
    parameter int IMAGE_BLOCKS = sdsr_pkg::IMAGE_BLOCKS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [7:0]                   s_mosi_byte,
    input  logic [sdsr_pkg::ADDR_W-1:0]  s_load_address,
    input  logic                         s_card_detect_open,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_miso_byte,
    output logic                         m_data_phase
);

    logic                        accept;
    logic                        xfer;
    logic                        load_we;
    sdsr_pkg::byte_op_t          op;
    logic                        rd_en;
    logic [sdsr_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  rd_data;

    assign accept  = s_valid && s_ready;
    assign xfer    = accept && !s_mode;
    assign load_we = accept && s_mode;

    // Command framing and block read sequencing.
    sdsr_cmd #(
        .IMAGE_BLOCKS (IMAGE_BLOCKS)
    ) u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .xfer      (xfer),
        .card_open (s_card_detect_open),
        .host_byte (s_mosi_byte),
        .op        (op),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    // Card image.
    sdsr_ram #(
        .WIDTH (8),
        .DEPTH (sdsr_pkg::STORE_BYTES)
    ) u_image (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (s_load_address),
        .wdata (s_mosi_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Byte selection, CRC and result register.
    sdsr_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (xfer),
        .op_in        (op),
        .rd_data      (rd_data),
        .take_ok      (s_ready),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_miso_byte  (m_miso_byte),
        .m_data_phase (m_data_phase)
    );

endmodule

>>> rtl/core/sdsr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module sdsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port whose data holds while not enabled.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/sdsr_cmd.sv
// Command framing and reply sequencer: gathers commands, tracks the read transfer
// and issues image reads. Uses sdsr_pkg.
module sdsr_cmd #(
    parameter int IMAGE_BLOCKS = sdsr_pkg::IMAGE_BLOCKS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         xfer,
    input  logic                         card_open,
    input  logic [7:0]                   host_byte,
    output sdsr_pkg::byte_op_t           op,
    output logic                         rd_en,
    output logic [sdsr_pkg::ADDR_W-1:0]  rd_addr
);

    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_REPLY     = 3'd1,
        PH_APP_CMD   = 3'd2,
        PH_APP_REPLY = 3'd3,
        PH_READ      = 3'd4
    } phase_t;

    localparam int SLOT_W = 3;
    localparam int BLK_LO_W = sdsr_pkg::ADDR_W - 9;
    localparam int BLOCK_LIMIT = (IMAGE_BLOCKS < sdsr_pkg::STORE_BLOCKS) ?
                                 IMAGE_BLOCKS : sdsr_pkg::STORE_BLOCKS;

    phase_t                        phase_reg, phase_next;
    logic [sdsr_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [sdsr_pkg::BLOCK_W-1:0]  block_reg, block_next;
    logic [7:0]                    cmd_reg [6];
    logic                          cmd_we;
    logic [SLOT_W-1:0]             slot;
    logic [sdsr_pkg::POS_W-1:0]    pos_m1;
    logic                          block_ok;

    assign pos_m1   = pos_reg - sdsr_pkg::POS_W'(1);
    assign block_ok = block_reg < sdsr_pkg::BLOCK_W'(BLOCK_LIMIT);
    assign slot     = (pos_reg > sdsr_pkg::POS_W'(5)) ? '0 : pos_reg[SLOT_W-1:0];
    assign rd_addr  = {block_reg[BLK_LO_W-1:0], pos_m1[8:0]};

    // Next state and the op handed to the output stage.
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        block_next    = block_reg;
        cmd_we        = 1'b0;
        rd_en         = 1'b0;
        op.sel        = sdsr_pkg::SEL_LIT;
        op.lit        = host_byte;
        op.data_phase = 1'b0;
        op.crc_upd    = 1'b0;
        op.crc_clr    = 1'b0;
        if (card_open) begin
            op.lit = sdsr_pkg::IDLE_BYTE;
        end else if (xfer) begin
            case (phase_reg)
                PH_CMD, PH_APP_CMD: begin
                    cmd_we   = 1'b1;
                    pos_next = sdsr_pkg::POS_W'(slot) + sdsr_pkg::POS_W'(1);
                    if (slot == '0 &&
                        (host_byte & sdsr_pkg::FRAME_MASK) != sdsr_pkg::FRAME_START) begin
                        pos_next = '0;
                    end
                    if (pos_next == sdsr_pkg::POS_W'(6)) begin
                        phase_next = (phase_reg == PH_CMD) ? PH_REPLY : PH_APP_REPLY;
                    end
                end
                PH_REPLY: begin
                    phase_next = PH_CMD;
                    pos_next   = '0;
                    case (cmd_reg[0][5:0])
                        sdsr_pkg::CMD_GO_IDLE, sdsr_pkg::CMD_STOP_TRANS: begin
                            op.lit = sdsr_pkg::R1_IDLE;
                        end
                        sdsr_pkg::CMD_SEND_IF_COND: begin
                            op.lit = sdsr_pkg::R1_ILLEGAL;
                        end
                        sdsr_pkg::CMD_READ_SINGLE: begin
                            op.lit     = sdsr_pkg::R1_READY;
                            op.crc_clr = 1'b1;
                            block_next = {cmd_reg[1], cmd_reg[2], cmd_reg[3][7:1]};
                            phase_next = PH_READ;
                        end
                        sdsr_pkg::CMD_APP_CMD: begin
                            phase_next = PH_APP_CMD;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_APP_REPLY: begin
                    phase_next = PH_CMD;
                    pos_next   = '0;
                    if (cmd_reg[0][5:0] == sdsr_pkg::ACMD_SEND_OP_COND) begin
                        op.lit = sdsr_pkg::R1_READY;
                    end
                end
                PH_READ: begin
                    op.data_phase = 1'b1;
                    if (pos_reg == '0) begin
                        op.lit = sdsr_pkg::START_TOKEN;
                    end else if (pos_reg <= sdsr_pkg::POS_W'(sdsr_pkg::BLOCK_BYTES)) begin
                        op.crc_upd = 1'b1;
                        if (block_ok) begin
                            op.sel = sdsr_pkg::SEL_MEM;
                            rd_en  = 1'b1;
                        end else begin
                            op.lit = sdsr_pkg::IDLE_BYTE;
                        end
                    end else if (pos_reg == sdsr_pkg::POS_W'(sdsr_pkg::BLOCK_BYTES + 1)) begin
                        op.sel = sdsr_pkg::SEL_CRC_HI;
                    end else begin
                        op.sel = sdsr_pkg::SEL_CRC_LO;
                    end
                    pos_next = pos_reg + sdsr_pkg::POS_W'(1);
                    if (pos_next >= sdsr_pkg::POS_W'(sdsr_pkg::READ_LENGTH)) begin
                        phase_next = PH_CMD;
                        pos_next   = '0;
                    end
                end
                default: begin
                    phase_next = PH_CMD;
                    pos_next   = '0;
                end
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CMD;
            pos_reg   <= '0;
            block_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            block_reg <= block_next;
        end
    end

    // Gathered command bytes.
    always_ff @(posedge aclk) begin
        if (cmd_we) begin
            cmd_reg[slot] <= host_byte;
        end
    end

    a_gather_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CMD || phase_reg == PH_APP_CMD) |-> pos_reg <= sdsr_pkg::POS_W'(5))
        else $error("gather position out of range");
    a_read_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ |-> pos_reg < sdsr_pkg::POS_W'(sdsr_pkg::READ_LENGTH))
        else $error("read position out of range");
    a_mem_only_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> phase_reg == PH_READ && xfer && block_ok)
        else $error("image read outside a block read");

endmodule

>>> rtl/core/sdsr_out.sv
// Output stage: picks the returned byte from the image read, a literal or the CRC,
// folds data bytes into the CRC and holds the result word. Uses sdsr_pkg.
module sdsr_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  sdsr_pkg::byte_op_t op_in,
    input  logic [7:0]         rd_data,
    output logic               take_ok,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [7:0]         m_miso_byte,
    output logic               m_data_phase
);

    logic               s1_valid_reg;
    sdsr_pkg::byte_op_t s1_op_reg;
    logic [15:0]        crc_reg, crc_next;
    logic               m_valid_reg;
    logic [7:0]         miso_reg;
    logic               data_reg;
    logic               adv;
    logic [7:0]         miso;

    assign adv          = !m_valid_reg || m_ready;
    assign take_ok      = !s1_valid_reg || adv;
    assign m_valid      = m_valid_reg;
    assign m_miso_byte  = miso_reg;
    assign m_data_phase = data_reg;

    // Byte selection for the word in the middle stage.
    always_comb begin
        case (s1_op_reg.sel)
            sdsr_pkg::SEL_LIT:    miso = s1_op_reg.lit;
            sdsr_pkg::SEL_MEM:    miso = rd_data;
            sdsr_pkg::SEL_CRC_HI: miso = crc_reg[15:8];
            sdsr_pkg::SEL_CRC_LO: miso = crc_reg[7:0];
            default:              miso = s1_op_reg.lit;
        endcase
        crc_next = crc_reg;
        if (s1_valid_reg && adv) begin
            if (s1_op_reg.crc_clr) begin
                crc_next = '0;
            end else if (s1_op_reg.crc_upd) begin
                crc_next = sdsr_pkg::crc_add(crc_reg, miso);
            end
        end
    end

    // Control of both stages and the running CRC.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            crc_reg      <= '0;
        end else begin
            crc_reg <= crc_next;
            if (take_ok) begin
                s1_valid_reg <= load;
            end
            if (adv) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (take_ok && load) begin
            s1_op_reg <= op_in;
        end
        if (adv && s1_valid_reg) begin
            miso_reg <= miso;
            data_reg <= s1_op_reg.data_phase;
        end
    end

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !take_ok |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");
    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_op_reg))
        else $error("middle stage lost a word while stalled");
    a_data_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_op_reg.sel != sdsr_pkg::SEL_LIT |-> s1_op_reg.data_phase)
        else $error("data or CRC byte outside the data phase");
    a_crc_ops: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(s1_op_reg.crc_clr && s1_op_reg.crc_upd))
        else $error("CRC cleared and updated at once");

endmodule

>>> bench/sdsr_reply_checker.sv
`timescale 1ns / 100ps
// Reply checker for the SD card SPI responder: watches both channels, predicts the
// byte the card returns for every exchange word and compares it with the result channel.
// Depends on sdsr_pkg for reply bytes, command indexes, image sizes and the CRC polynomial.
module sdsr_reply_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_mode,
    input  logic [7:0]                  s_mosi_byte,
    input  logic [sdsr_pkg::ADDR_W-1:0] s_load_address,
    input  logic                        s_card_detect_open,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [7:0]                  m_miso_byte,
    input  logic                        m_data_phase,
    output int                          mismatches,
    output int                          outstanding
);
    import sdsr_pkg::*;

    typedef enum logic [2:0] {
        AWAIT_CMD,
        CMD_R1,
        AWAIT_ACMD,
        ACMD_R1,
        READ_BLOCK
    } card_phase_t;

    typedef struct packed {
        logic [7:0] miso;
        logic       data_phase;
    } reply_t;

    // Shadow of the card state; the image survives reset like the real store.
    card_phase_t   card_phase;
    logic [9:0]    xfer_pos;
    logic [7:0]    cmd_frame [0:5];
    logic [22:0]   read_block;
    logic [15:0]   read_crc;
    logic [7:0]    image [0:STORE_BYTES-1];
    reply_t        expected_replies [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // CRC-16 over one byte, shifted in MSB first.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ data[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Blocks past the image (or past the store) read back as idle bytes.
    function automatic logic [7:0] image_at(input logic [22:0] blk, input int offset);
        if (blk >= BLOCK_LIMIT) begin
            return IDLE_BYTE;
        end
        return image[int'(blk) * BLOCK_BYTES + offset];
    endfunction

    // Advance the card by one exchanged word and work out what it shifts back.
    task automatic predict_reply(input logic [7:0] host, output reply_t r);
        r.miso       = host;
        r.data_phase = 1'b0;
        case (card_phase)
            AWAIT_CMD, AWAIT_ACMD: begin
                if (xfer_pos > 10'd5) begin
                    xfer_pos = '0;
                end
                cmd_frame[xfer_pos] = host;
                xfer_pos = xfer_pos + 10'd1;
                // A first byte without the 01 start bits is dropped to resync the frame.
                if (xfer_pos == 10'd1 && (cmd_frame[0] & FRAME_MASK) != FRAME_START) begin
                    xfer_pos = '0;
                end
                if (xfer_pos == 10'd6) begin
                    if (card_phase == AWAIT_CMD) begin
                        card_phase = CMD_R1;
                    end else begin
                        card_phase = ACMD_R1;
                    end
                end
            end
            CMD_R1: begin
                card_phase = AWAIT_CMD;
                xfer_pos   = '0;
                case (cmd_frame[0][5:0])
                    CMD_GO_IDLE:      r.miso = R1_IDLE;
                    CMD_SEND_IF_COND: r.miso = R1_ILLEGAL;
                    CMD_STOP_TRANS:   r.miso = R1_IDLE;
                    CMD_READ_SINGLE: begin
                        r.miso     = R1_READY;
                        read_block = {cmd_frame[1], cmd_frame[2], cmd_frame[3][7:1]};
                        read_crc   = '0;
                        card_phase = READ_BLOCK;
                    end
                    CMD_APP_CMD:      card_phase = AWAIT_ACMD;
                    default: ;
                endcase
            end
            ACMD_R1: begin
                card_phase = AWAIT_CMD;
                xfer_pos   = '0;
                if (cmd_frame[0][5:0] == ACMD_SEND_OP_COND) begin
                    r.miso = R1_READY;
                end
            end
            READ_BLOCK: begin
                r.data_phase = 1'b1;
                if (xfer_pos == 10'd0) begin
                    r.miso = START_TOKEN;
                end else if (xfer_pos <= BLOCK_BYTES) begin
                    r.miso   = image_at(read_block, int'(xfer_pos) - 1);
                    read_crc = crc16_next(read_crc, r.miso);
                end else if (xfer_pos == BLOCK_BYTES + 1) begin
                    r.miso = read_crc[15:8];
                end else begin
                    r.miso = read_crc[7:0];
                end
                xfer_pos = xfer_pos + 10'd1;
                if (xfer_pos >= READ_LENGTH) begin
                    card_phase = AWAIT_CMD;
                    xfer_pos   = '0;
                end
            end
            default: begin
                card_phase = AWAIT_CMD;
                xfer_pos   = '0;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            card_phase = AWAIT_CMD;
            xfer_pos   = '0;
            read_block = '0;
            read_crc   = '0;
            foreach (cmd_frame[i]) cmd_frame[i] = '0;
            expected_replies.delete();
        end else begin
            // Result side first: a reply never leaves in the cycle its word arrives.
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: reply with none expected: miso %02h data_phase %0b",
                                 $time, m_miso_byte, m_data_phase);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (m_miso_byte !== want.miso || m_data_phase !== want.data_phase) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected miso %02h data_phase %0b, got %02h %0b",
                                     $time, want.miso, want.data_phase,
                                     m_miso_byte, m_data_phase);
                        end
                    end
                end
            end

            // Input side: loads fill the image, exchanges queue a reply.
            if (s_valid && s_ready) begin
                if (s_mode) begin
                    image[s_load_address] = s_mosi_byte;
                end else if (s_card_detect_open) begin
                    want.miso       = IDLE_BYTE;
                    want.data_phase = 1'b0;
                    expected_replies.push_back(want);
                end else begin
                    predict_reply(s_mosi_byte, want);
                    expected_replies.push_back(want);
                end
            end
        end
        outstanding = expected_replies.size();
    end

endmodule

>>> bench/tb_sd_card_spi_responder_core.sv
`timescale 1ns / 100ps
// Testbench top for the SD card SPI responder: drives host exchanges, image loads and
// card removal, paces both channels and gives the verdict.
// Depends on sdsr_pkg, sd_card_spi_responder_core and sdsr_reply_checker.
module tb_sd_card_spi_responder_core;
    import sdsr_pkg::*;

    localparam int STAGE1_START = 500;
    localparam int STAGE2_START = 950;
    localparam int FINAL_WORDS  = 1650;
    localparam int HOLD_AT      = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic              aclk;
    logic              aresetn            = 1'b0;
    logic              s_valid            = 1'b0;
    logic              s_ready;
    logic              s_mode             = 1'b0;
    logic [7:0]        s_mosi_byte        = '0;
    logic [ADDR_W-1:0] s_load_address     = '0;
    logic              s_card_detect_open = 1'b0;
    logic              m_valid;
    logic              m_ready            = 1'b0;
    logic [7:0]        m_miso_byte;
    logic              m_data_phase;

    int mismatches;
    int outstanding;
    int words_sent        = 0;
    int sender_idle_pct   = 38;
    int receiver_idle_pct = 72;
    int stall_cycles      = 0;
    int filled_block      = 0;
    bit noise_on          = 1'b0;

    sd_card_spi_responder_core uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_mosi_byte        (s_mosi_byte),
        .s_load_address     (s_load_address),
        .s_card_detect_open (s_card_detect_open),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_miso_byte        (m_miso_byte),
        .m_data_phase       (m_data_phase)
    );

    sdsr_reply_checker reply_chk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_mosi_byte        (s_mosi_byte),
        .s_load_address     (s_load_address),
        .s_card_detect_open (s_card_detect_open),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_miso_byte        (m_miso_byte),
        .m_data_phase       (m_data_phase),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one word, with random idle cycles ahead of it, and wait for it to be taken.
    task automatic send_word(input logic mode, input logic [7:0] data,
                             input logic [ADDR_W-1:0] addr, input logic absent);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_mode             <= mode;
        s_mosi_byte        <= data;
        s_load_address     <= addr;
        s_card_detect_open <= absent;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        // Pacing stages: sender light and receiver heavy, then swapped, then none.
        if (words_sent >= STAGE2_START) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end else if (words_sent >= STAGE1_START) begin
            sender_idle_pct   = 72;
            receiver_idle_pct = 38;
        end
    endtask

    // One host byte; in the random part a card removal or a stray load may slip in first.
    task automatic exchange_byte(input logic [7:0] data);
        if (noise_on && $urandom_range(0, 15) == 0) begin
            send_word(1'b0, 8'($urandom), ADDR_W'($urandom), 1'b1);
        end
        if (noise_on && $urandom_range(0, 31) == 0) begin
            send_word(1'b1, 8'($urandom), ADDR_W'($urandom), 1'($urandom));
        end
        send_word(1'b0, data, ADDR_W'($urandom), 1'b0);
    endtask

    // A full command frame followed by the R1 slot.
    task automatic issue_command(input logic [5:0] idx, input logic [31:0] arg);
        exchange_byte({2'b01, idx});
        for (int i = 3; i >= 0; i--) begin
            exchange_byte(arg[8*i +: 8]);
        end
        exchange_byte(8'($urandom));
        exchange_byte(8'($urandom));
    endtask

    // CMD17 for one block, then clock out token, data and CRC.
    task automatic read_block_at(input logic [22:0] blk);
        issue_command(CMD_READ_SINGLE, {blk, 9'($urandom)});
        repeat (READ_LENGTH) exchange_byte(8'($urandom));
    endtask

    function automatic bit is_known_cmd(input logic [5:0] idx);
        return idx == CMD_GO_IDLE || idx == CMD_SEND_IF_COND || idx == CMD_STOP_TRANS ||
               idx == CMD_READ_SINGLE || idx == CMD_APP_CMD;
    endfunction

    // One random transaction, mostly well-formed commands with random content.
    task automatic random_transaction();
        int         kind;
        logic [5:0] idx;
        logic [7:0] b;
        kind = $urandom_range(0, 19);
        case (kind)
            0:      read_block_at(23'(filled_block));
            1:      read_block_at(23'($urandom_range(IMAGE_BLOCKS, 23'h7FFFFF)));
            2, 3:   issue_command(CMD_GO_IDLE, $urandom);
            4, 5:   issue_command(CMD_SEND_IF_COND, $urandom);
            6, 7:   issue_command(CMD_STOP_TRANS, $urandom);
            8, 9, 10: begin
                idx = 6'($urandom);
                while (is_known_cmd(idx)) idx = 6'($urandom);
                issue_command(idx, $urandom);
            end
            11, 12: begin
                issue_command(CMD_APP_CMD, $urandom);
                issue_command(ACMD_SEND_OP_COND, $urandom);
            end
            13, 14: begin
                issue_command(CMD_APP_CMD, $urandom);
                idx = 6'($urandom);
                while (idx == ACMD_SEND_OP_COND) idx = 6'($urandom);
                issue_command(idx, $urandom);
            end
            15, 16: begin
                // Resync noise: bytes that can never start a frame.
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom);
                    if (b[7:6] == 2'b01) begin
                        b[7] = 1'b1;
                    end
                    exchange_byte(b);
                end
            end
            default: begin
                repeat ($urandom_range(1, 3)) begin
                    send_word(1'b1, 8'($urandom), ADDR_W'($urandom), 1'($urandom));
                    send_word(1'b0, 8'($urandom), ADDR_W'($urandom), 1'b1);
                end
            end
        endcase
    endtask

    // Result side pacing, with one long hold-off so the pipeline backs up.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && words_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
            end
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Image extremes, the top one loaded with the card pulled.
        send_word(1'b1, 8'h00, '0, 1'b0);
        send_word(1'b1, 8'hFF, '1, 1'b1);
        // A byte without start bits is dropped.
        send_word(1'b0, 8'h80, '0, 1'b0);
        // CMD0 with the card pulled for one word in the middle of the frame.
        exchange_byte({2'b01, CMD_GO_IDLE});
        send_word(1'b0, 8'h3C, '1, 1'b1);
        repeat (4) exchange_byte(8'h00);
        exchange_byte(8'h95);
        exchange_byte(8'hFF);
        // CMD55 then ACMD41.
        issue_command(CMD_APP_CMD, 32'h0000_0000);
        issue_command(ACMD_SEND_OP_COND, 32'h4000_0000);

        // Load one whole image block so it can be read back.
        filled_block = $urandom_range(0, IMAGE_BLOCKS - 1);
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            send_word(1'b1, 8'($urandom), ADDR_W'(filled_block * BLOCK_BYTES + i),
                      1'($urandom));
        end

        noise_on = 1'b1;
        // First block past the image reads as idle bytes.
        read_block_at(23'(IMAGE_BLOCKS));
        while (words_sent < STAGE2_START) random_transaction();
        read_block_at(23'(filled_block));
        while (words_sent < FINAL_WORDS) random_transaction();

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sdsr_pkg.sv
rtl/core/sdsr_ram.sv
rtl/core/sdsr_cmd.sv
rtl/core/sdsr_out.sv
rtl/core/sd_card_spi_responder_core.sv
bench/sdsr_reply_checker.sv
bench/tb_sd_card_spi_responder_core.sv
